### rtl/bpfd_pkg.sv
// ----------------------------------------------------------------------------
// bpfd_pkg - shared types and constants for the packet FIFO
// Command and status codes, controller states and the per-cell control word.
// ----------------------------------------------------------------------------
package bpfd_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int NODE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF = 30;

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 3;
    localparam int LIMIT_BITS  = 7;
    localparam int COUNT_BITS  = 7;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd64;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 7'd127;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD = 2'd0,
        CMD_FWD = 2'd1,
        CMD_CNT = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_ADDED = 3'd0,
        ST_DUP   = 3'd1,
        ST_FWD   = 3'd2,
        ST_EMPTY = 3'd3,
        ST_COUNT = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DONE
    } t_state;

    // per-cell control: take neighbor entry, take new entry, capture compares
    typedef struct packed {
        logic shift;
        logic load;
        logic sample;
    } t_cell_ctrl;

endpackage

### rtl/bpfd_if.sv
// ----------------------------------------------------------------------------
// bpfd_if - channel interfaces of the packet FIFO
// Command channel, result channel and limit register write channel.
// ----------------------------------------------------------------------------
interface bpfd_cmd_if #(
    parameter int NODE_BITS = 16,
    parameter int TIME_BITS = 30
);
    import bpfd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   cmd;
    logic [NODE_BITS-1:0]  pkt_source;
    logic [NODE_BITS-1:0]  destination;
    logic [TIME_BITS-1:0]  timestamp;
    logic [TIME_BITS-1:0]  start_time;
    logic [TIME_BITS-1:0]  end_time;

    modport source (output valid, cmd, pkt_source, destination, timestamp,
                    start_time, end_time, input ready);
    modport sink   (input valid, cmd, pkt_source, destination, timestamp,
                    start_time, end_time, output ready);
endinterface

interface bpfd_res_if #(
    parameter int NODE_BITS = 16,
    parameter int TIME_BITS = 30
);
    import bpfd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [NODE_BITS-1:0]   out_source;
    logic [NODE_BITS-1:0]   out_destination;
    logic [TIME_BITS-1:0]   out_timestamp;
    logic [COUNT_BITS-1:0]  match_count;

    modport source (output valid, status, out_source, out_destination,
                    out_timestamp, match_count, input ready);
    modport sink   (input valid, status, out_source, out_destination,
                    out_timestamp, match_count, output ready);
endinterface

interface bpfd_cfg_if;
    import bpfd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LIMIT_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/bounded_packet_fifo_dedup_count.sv
// ----------------------------------------------------------------------------
// bounded_packet_fifo_dedup_count - bounded packet FIFO with duplicate check
// Arrival-ordered packet store with add, forward-oldest and range count.
// ----------------------------------------------------------------------------
// Entries sit in a row of DEPTH cells, packed from cell 0 (oldest) upward;
// a forward or an eviction shifts the whole row one cell toward the head.
// Every command passes S_EVAL and then S_DONE: in S_EVAL each cell compares
// its entry against the registered command and latches its match bits; in
// S_DONE the duplicate OR and the population count of the count bits settle
// and, once the output register can take a result, the row is updated and the
// result is loaded into it; a new command is taken along with that update.
// Command code 3 is consumed and gives no result.
// The limit register may be written at any time the block is idle; zero acts
// as one and values above DEPTH act as DEPTH.
module bounded_packet_fifo_dedup_count #(
    parameter int DEPTH     = bpfd_pkg::DEPTH_DEF,
    parameter int NODE_BITS = bpfd_pkg::NODE_BITS_DEF,
    parameter int TIME_BITS = bpfd_pkg::TIME_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpfd_cmd_if.sink   i_pkt,
    bpfd_res_if.source o_res,
    bpfd_cfg_if.sink   i_cfg
);
    import bpfd_pkg::*;

    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (OCC_W > LIMIT_BITS) ? OCC_W : LIMIT_BITS;
    localparam int SUM_W  = OCC_W + COUNT_BITS;

    // controller
    t_state r_state;
    t_state n_state;
    logic   in_fire;
    logic   out_can_load;
    logic   do_update;
    logic   sample_en;

    // registered command
    t_cmd                 r_cmd;
    logic [NODE_BITS-1:0] r_q_src;
    logic [NODE_BITS-1:0] r_q_dst;
    logic [TIME_BITS-1:0] r_q_ts;
    logic [TIME_BITS-1:0] r_q_lo;
    logic [TIME_BITS-1:0] r_q_hi;

    logic [LIMIT_BITS-1:0] r_mem_limit;
    logic [OCC_W-1:0]      r_occ;
    logic [OCC_W-1:0]      n_occ;

    // cell row
    logic [DEPTH-1:0]     cell_valid;
    logic [NODE_BITS-1:0] cell_src [DEPTH];
    logic [NODE_BITS-1:0] cell_dst [DEPTH];
    logic [TIME_BITS-1:0] cell_ts  [DEPTH];
    logic [DEPTH-1:0]     hit_dup;
    logic [DEPTH-1:0]     hit_cnt;

    // decision
    logic             any_dup;
    logic [OCC_W-1:0] hit_sum;
    logic [CMP_W-1:0] lim_eff;
    logic             full;
    logic             upd_shift;
    logic             upd_load;
    logic [IDX_W-1:0] wr_idx;

    logic                  res_valid;
    t_status               res_status;
    logic [NODE_BITS-1:0]  res_src;
    logic [NODE_BITS-1:0]  res_dst;
    logic [TIME_BITS-1:0]  res_ts;
    logic [COUNT_BITS-1:0] res_cnt;

    // output register
    logic                  r_out_valid;
    t_status               r_status;
    logic [NODE_BITS-1:0]  r_src;
    logic [NODE_BITS-1:0]  r_dst;
    logic [TIME_BITS-1:0]  r_ts;
    logic [COUNT_BITS-1:0] r_cnt;

    // ---------------------------------------------------------------- control
    assign out_can_load = !r_out_valid || o_res.ready;
    assign in_fire      = i_pkt.valid && i_pkt.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_can_load) n_state = in_fire ? S_EVAL : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        i_pkt.ready = 1'b0;
        do_update   = 1'b0;
        sample_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_pkt.ready = 1'b1;
            end
            S_EVAL: begin
                sample_en = 1'b1;
            end
            S_DONE: begin
                i_pkt.ready = out_can_load;
                do_update   = out_can_load;
            end
            default: begin
                i_pkt.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mem_limit <= LIMIT_RESET;
            r_occ       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) r_mem_limit <= i_cfg.data;
            if (do_update) r_occ <= n_occ;
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd   <= t_cmd'(i_pkt.cmd);
            r_q_src <= i_pkt.pkt_source;
            r_q_dst <= i_pkt.destination;
            r_q_ts  <= i_pkt.timestamp;
            r_q_lo  <= i_pkt.start_time;
            r_q_hi  <= i_pkt.end_time;
        end
    end

    // ------------------------------------------------------------- cell row
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_ctrl           ctrl;
        logic                 nb_valid;
        logic [NODE_BITS-1:0] nb_src;
        logic [NODE_BITS-1:0] nb_dst;
        logic [TIME_BITS-1:0] nb_ts;

        assign ctrl.shift  = do_update && upd_shift;
        assign ctrl.load   = do_update && upd_load && (wr_idx == IDX_W'(gi));
        assign ctrl.sample = sample_en;

        if (gi == DEPTH - 1) begin : g_last
            assign nb_valid = 1'b0;
            assign nb_src   = '0;
            assign nb_dst   = '0;
            assign nb_ts    = '0;
        end else begin : g_mid
            assign nb_valid = cell_valid[gi+1];
            assign nb_src   = cell_src[gi+1];
            assign nb_dst   = cell_dst[gi+1];
            assign nb_ts    = cell_ts[gi+1];
        end

        bpfd_cell #(
            .NODE_BITS (NODE_BITS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_nb_valid (nb_valid),
            .i_nb_src   (nb_src),
            .i_nb_dst   (nb_dst),
            .i_nb_ts    (nb_ts),
            .i_q_src    (r_q_src),
            .i_q_dst    (r_q_dst),
            .i_q_ts     (r_q_ts),
            .i_q_lo     (r_q_lo),
            .i_q_hi     (r_q_hi),
            .o_valid    (cell_valid[gi]),
            .o_src      (cell_src[gi]),
            .o_dst      (cell_dst[gi]),
            .o_ts       (cell_ts[gi]),
            .o_hit_dup  (hit_dup[gi]),
            .o_hit_cnt  (hit_cnt[gi])
        );
    end

    // ------------------------------------------------------------- decision
    assign any_dup = |hit_dup;

    // population count of the latched match bits
    assign hit_sum = OCC_W'($countones(hit_cnt));

    always_comb begin
        lim_eff = CMP_W'(r_mem_limit);
        if (lim_eff == '0) lim_eff = CMP_W'(1);
        if (lim_eff > CMP_W'(DEPTH)) lim_eff = CMP_W'(DEPTH);
    end

    assign full = CMP_W'(r_occ) >= lim_eff;

    always_comb begin
        upd_shift  = 1'b0;
        upd_load   = 1'b0;
        wr_idx     = '0;
        n_occ      = r_occ;
        res_valid  = 1'b0;
        res_status = ST_ADDED;
        res_src    = '0;
        res_dst    = '0;
        res_ts     = '0;
        res_cnt    = '0;
        case (r_cmd)
            CMD_ADD: begin
                res_valid = 1'b1;
                if (any_dup) begin
                    res_status = ST_DUP;
                end else begin
                    upd_load = 1'b1;
                    if (full) begin
                        // evict head, append at the last occupied cell
                        upd_shift = 1'b1;
                        wr_idx    = IDX_W'(r_occ - 1'b1);
                    end else begin
                        wr_idx = IDX_W'(r_occ);
                        n_occ  = r_occ + 1'b1;
                    end
                end
            end
            CMD_FWD: begin
                res_valid = 1'b1;
                if (r_occ == '0) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_status = ST_FWD;
                    res_src    = cell_src[0];
                    res_dst    = cell_dst[0];
                    res_ts     = cell_ts[0];
                    upd_shift  = 1'b1;
                    n_occ      = r_occ - 1'b1;
                end
            end
            CMD_CNT: begin
                res_valid  = 1'b1;
                res_status = ST_COUNT;
                if (SUM_W'(hit_sum) > SUM_W'(COUNT_MAX)) begin
                    res_cnt = COUNT_MAX;
                end else begin
                    res_cnt = COUNT_BITS'(hit_sum);
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // -------------------------------------------------------- output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_update && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_update && res_valid) begin
            r_status <= res_status;
            r_src    <= res_src;
            r_dst    <= res_dst;
            r_ts     <= res_ts;
            r_cnt    <= res_cnt;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_status;
    assign o_res.out_source      = r_src;
    assign o_res.out_destination = r_dst;
    assign o_res.out_timestamp   = r_ts;
    assign o_res.match_count     = r_cnt;

    // ------------------------------------------------------------ assertions
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        OCC_W'(DEPTH) >= r_occ)
        else $error("occupancy beyond depth");

    a_row_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cell_valid) == 32'(r_occ))
        else $error("valid cells disagree with occupancy");

    a_fwd_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_update && r_cmd == CMD_FWD && r_occ != '0)
        |=> r_occ == $past(r_occ) - 1'b1)
        else $error("forward did not pop one entry");

    a_no_take_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> !i_pkt.ready)
        else $error("command taken during compare cycle");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_update && r_cmd == CMD_ADD && !any_dup && full)
        |=> r_occ == $past(r_occ))
        else $error("eviction changed occupancy");

endmodule

### rtl/bpfd_cell.sv
// ----------------------------------------------------------------------------
// bpfd_cell - one storage cell of the packet chain
// Holds one entry, shifts toward the head, compares against the query.
// ----------------------------------------------------------------------------
module bpfd_cell #(
    parameter int NODE_BITS = 16,
    parameter int TIME_BITS = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bpfd_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_nb_valid,
    input  logic [NODE_BITS-1:0]  i_nb_src,
    input  logic [NODE_BITS-1:0]  i_nb_dst,
    input  logic [TIME_BITS-1:0]  i_nb_ts,
    input  logic [NODE_BITS-1:0]  i_q_src,
    input  logic [NODE_BITS-1:0]  i_q_dst,
    input  logic [TIME_BITS-1:0]  i_q_ts,
    input  logic [TIME_BITS-1:0]  i_q_lo,
    input  logic [TIME_BITS-1:0]  i_q_hi,
    output logic                  o_valid,
    output logic [NODE_BITS-1:0]  o_src,
    output logic [NODE_BITS-1:0]  o_dst,
    output logic [TIME_BITS-1:0]  o_ts,
    output logic                  o_hit_dup,
    output logic                  o_hit_cnt
);
    import bpfd_pkg::*;

    logic                 r_valid;
    logic [NODE_BITS-1:0] r_src;
    logic [NODE_BITS-1:0] r_dst;
    logic [TIME_BITS-1:0] r_ts;
    logic                 r_hit_dup;
    logic                 r_hit_cnt;
    logic                 n_hit_dup;
    logic                 n_hit_cnt;

    assign n_hit_dup = r_valid && (r_src == i_q_src) && (r_dst == i_q_dst)
                       && (r_ts == i_q_ts);
    assign n_hit_cnt = r_valid && (r_dst == i_q_dst)
                       && (r_ts >= i_q_lo) && (r_ts <= i_q_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_hit_dup <= 1'b0;
            r_hit_cnt <= 1'b0;
        end else begin
            // new entry wins over the shift when both land here
            if (i_ctrl.load) begin
                r_valid <= 1'b1;
            end else if (i_ctrl.shift) begin
                r_valid <= i_nb_valid;
            end
            if (i_ctrl.sample) begin
                r_hit_dup <= n_hit_dup;
                r_hit_cnt <= n_hit_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_src <= i_q_src;
            r_dst <= i_q_dst;
            r_ts  <= i_q_ts;
        end else if (i_ctrl.shift) begin
            r_src <= i_nb_src;
            r_dst <= i_nb_dst;
            r_ts  <= i_nb_ts;
        end
    end

    assign o_valid   = r_valid;
    assign o_src     = r_src;
    assign o_dst     = r_dst;
    assign o_ts      = r_ts;
    assign o_hit_dup = r_hit_dup;
    assign o_hit_cnt = r_hit_cnt;

endmodule

### verif/bounded_packet_fifo_dedup_count_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_packet_fifo_dedup_count_tb - self-checking bench for the packet FIFO
// Directed table, then random phases with varied limits. Each accepted
// command updates a local FIFO model; results are compared field by field.
// ----------------------------------------------------------------------------
module bounded_packet_fifo_dedup_count_tb;
    import bpfd_pkg::*;

    localparam int SLOTS      = DEPTH_DEF;
    localparam int NB         = NODE_BITS_DEF;
    localparam int TB         = TIME_BITS_DEF;
    localparam int MAX_CYCLES = 600000;
    localparam int LONG_HOLD  = 200;
    localparam int DRAIN_WAIT = 8;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 165;

    localparam logic [TB-1:0] TS_MAX      = '1;
    localparam logic [NB-1:0] NODE_MAX    = '1;
    localparam logic [NB-1:0] NARROW_DST  = 16'h5a5a;

    typedef struct packed {
        t_status               status;
        logic [NB-1:0]         src;
        logic [NB-1:0]         dst;
        logic [TB-1:0]         ts;
        logic [COUNT_BITS-1:0] count;
    } t_result;

    typedef struct {
        t_cmd          cmd;
        logic [NB-1:0] src;
        logic [NB-1:0] dst;
        logic [TB-1:0] ts;
        logic [TB-1:0] t_lo;
        logic [TB-1:0] t_hi;
        bit            typed;
        t_result       typed_res;
    } t_packet_cmd;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    bpfd_cmd_if #(.NODE_BITS(NB), .TIME_BITS(TB)) pkt_if ();
    bpfd_res_if #(.NODE_BITS(NB), .TIME_BITS(TB)) res_if ();
    bpfd_cfg_if cfg_if ();

    bounded_packet_fifo_dedup_count #(
        .DEPTH    (SLOTS),
        .NODE_BITS(NB),
        .TIME_BITS(TB)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pkt  (pkt_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    // local FIFO model
    logic [NB-1:0]         fifo_src [SLOTS];
    logic [NB-1:0]         fifo_dst [SLOTS];
    logic [TB-1:0]         fifo_ts  [SLOTS];
    bit                    fifo_vld [SLOTS];
    int unsigned           fifo_head = 0;
    int unsigned           fifo_tail = 0;
    int unsigned           fifo_occ  = 0;
    logic [LIMIT_BITS-1:0] limit_reg = LIMIT_RESET;

    t_result     awaited_results [$];
    bit          cur_typed     = 1'b0;
    t_result     cur_typed_res = '0;
    bit          sender_idle   = 1'b1;
    bit          sink_idle     = 1'b1;
    bit          hold_request  = 1'b0;
    int          errors        = 0;
    int          results_seen  = 0;
    int          cmds_sent     = 0;
    int unsigned peak_occ      = 0;
    int unsigned peak_count    = 0;
    int unsigned cycle_count   = 0;

    function automatic int unsigned active_limit();
        int unsigned lim;
        lim = 32'(limit_reg);
        if (lim == 0) lim = 1;
        if (lim > SLOTS) lim = SLOTS;
        return lim;
    endfunction

    function automatic void drop_head();
        if (fifo_occ != 0) begin
            fifo_vld[fifo_head] = 1'b0;
            fifo_head = (fifo_head + 1) % SLOTS;
            fifo_occ--;
        end
    endfunction

    function automatic bit predict_fifo(input t_packet_cmd p, output t_result r);
        bit          dup;
        int unsigned n;
        dup = 1'b0;
        n   = 0;
        r   = '0;
        case (p.cmd)
            CMD_ADD: begin
                for (int i = 0; i < SLOTS; i++)
                    if (fifo_vld[i] && fifo_src[i] == p.src && fifo_dst[i] == p.dst &&
                        fifo_ts[i] == p.ts)
                        dup = 1'b1;
                if (dup) begin
                    r.status = ST_DUP;
                    return 1'b1;
                end
                if (fifo_occ >= active_limit()) drop_head();
                fifo_src[fifo_tail] = p.src;
                fifo_dst[fifo_tail] = p.dst;
                fifo_ts[fifo_tail]  = p.ts;
                fifo_vld[fifo_tail] = 1'b1;
                fifo_tail = (fifo_tail + 1) % SLOTS;
                fifo_occ++;
                if (fifo_occ > peak_occ) peak_occ = fifo_occ;
                r.status = ST_ADDED;
                return 1'b1;
            end
            CMD_FWD: begin
                if (fifo_occ == 0) begin
                    r.status = ST_EMPTY;
                    return 1'b1;
                end
                r.status = ST_FWD;
                r.src    = fifo_src[fifo_head];
                r.dst    = fifo_dst[fifo_head];
                r.ts     = fifo_ts[fifo_head];
                drop_head();
                return 1'b1;
            end
            CMD_CNT: begin
                for (int i = 0; i < SLOTS; i++)
                    if (fifo_vld[i] && fifo_dst[i] == p.dst && fifo_ts[i] >= p.t_lo &&
                        fifo_ts[i] <= p.t_hi)
                        n++;
                if (n > COUNT_MAX) n = COUNT_MAX;
                if (n > peak_count) peak_count = n;
                r.status = ST_COUNT;
                r.count  = COUNT_BITS'(n);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic check_result(input t_result got);
        t_result want;
        if (awaited_results.size() == 0) begin
            $display("%0t: result with nothing expected: status %0d", $time, got.status);
            errors++;
        end else begin
            want = awaited_results.pop_front();
            results_seen++;
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.src !== want.src) begin
                $display("%0t: out_source mismatch: expected %h, got %h",
                         $time, want.src, got.src);
                errors++;
            end
            if (got.dst !== want.dst) begin
                $display("%0t: out_destination mismatch: expected %h, got %h",
                         $time, want.dst, got.dst);
                errors++;
            end
            if (got.ts !== want.ts) begin
                $display("%0t: out_timestamp mismatch: expected %h, got %h",
                         $time, want.ts, got.ts);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: match_count mismatch: expected %0d, got %0d",
                         $time, want.count, got.count);
                errors++;
            end
        end
    endtask

    // sample handshakes at the rising edge
    always @(posedge i_clk) begin
        t_result     got;
        t_result     predicted;
        t_packet_cmd seen;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.status = t_status'(res_if.status);
                got.src    = res_if.out_source;
                got.dst    = res_if.out_destination;
                got.ts     = res_if.out_timestamp;
                got.count  = res_if.match_count;
                check_result(got);
            end
            if (pkt_if.valid && pkt_if.ready) begin
                seen.cmd       = t_cmd'(pkt_if.cmd);
                seen.src       = pkt_if.pkt_source;
                seen.dst       = pkt_if.destination;
                seen.ts        = pkt_if.timestamp;
                seen.t_lo      = pkt_if.start_time;
                seen.t_hi      = pkt_if.end_time;
                seen.typed     = cur_typed;
                seen.typed_res = cur_typed_res;
                cmds_sent++;
                if (predict_fifo(seen, predicted))
                    awaited_results.push_back(cur_typed ? cur_typed_res : predicted);
            end
            if (cfg_if.valid && cfg_if.ready) limit_reg = cfg_if.data;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("bounded_packet_fifo_dedup_count test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // result side: random stalls plus one long hold-off
    initial begin
        int stall_left;
        stall_left    = 0;
        res_if.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else if (sink_idle && $urandom_range(0, 99) < 35) begin
                res_if.ready = 1'b0;
                stall_left   = pick_gap();
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    task automatic send_packet(input t_packet_cmd p);
        int gap;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0) begin
            pkt_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_typed          = p.typed;
        cur_typed_res      = p.typed_res;
        pkt_if.cmd         = p.cmd;
        pkt_if.pkt_source  = p.src;
        pkt_if.destination = p.dst;
        pkt_if.timestamp   = p.ts;
        pkt_if.start_time  = p.t_lo;
        pkt_if.end_time    = p.t_hi;
        pkt_if.valid       = 1'b1;
        @(posedge i_clk);
        while (!pkt_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // write only once every result is back and any no-result command is done
    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        pkt_if.valid = 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        cfg_if.data  = value;
        cfg_if.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic t_packet_cmd random_packet(input int add_pct, input bit narrow);
        t_packet_cmd p;
        int          roll;
        int          pick;
        int unsigned lo;
        int unsigned hi;
        p.src       = NB'($urandom);
        p.dst       = NB'($urandom);
        p.ts        = TB'($urandom);
        p.t_lo      = TB'($urandom);
        p.t_hi      = TB'($urandom);
        p.typed     = 1'b0;
        p.typed_res = '0;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) p.cmd = CMD_ADD;
        else if (roll < add_pct + (100 - add_pct) / 2) p.cmd = CMD_FWD;
        else if (roll < 97) p.cmd = CMD_CNT;
        else p.cmd = CMD_NOP;
        pick = $urandom_range(0, SLOTS - 1);
        roll = $urandom_range(0, 99);
        if (p.cmd == CMD_ADD) begin
            if (roll < 25 && fifo_vld[pick]) begin
                // replay a stored triple to hit the duplicate path
                p.src = fifo_src[pick];
                p.dst = fifo_dst[pick];
                p.ts  = fifo_ts[pick];
            end else begin
                if (roll < 70) begin
                    p.src = NB'($urandom_range(0, 3));
                    p.dst = NB'($urandom_range(0, 3));
                    p.ts  = TB'($urandom_range(0, 15));
                end
                if (narrow) p.dst = NARROW_DST;
            end
        end else if (p.cmd == CMD_CNT) begin
            if (narrow) p.dst = NARROW_DST;
            else if (roll < 60 && fifo_vld[pick]) p.dst = fifo_dst[pick];
            else if (roll < 80) p.dst = NB'($urandom_range(0, 3));
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                p.t_lo = '0;
                p.t_hi = TS_MAX;
            end else if (roll < 60 && fifo_vld[pick]) begin
                lo = 32'(fifo_ts[pick]);
                hi = 32'(fifo_ts[pick]);
                lo = (lo < 2) ? 0 : lo - $urandom_range(0, 2);
                hi = (hi > TS_MAX - 2) ? 32'(TS_MAX) : hi + $urandom_range(0, 2);
                p.t_lo = TB'(lo);
                p.t_hi = TB'(hi);
            end else if (roll < 75) begin
                p.t_lo = TB'($urandom_range(0, 15));
                p.t_hi = TB'($urandom_range(0, 15));
            end
        end
        return p;
    endfunction

    t_packet_cmd script [$];

    task automatic add_row(input t_cmd c, input logic [NB-1:0] s, input logic [NB-1:0] d,
                           input logic [TB-1:0] t, input logic [TB-1:0] lo,
                           input logic [TB-1:0] hi, input bit typed, input t_status st,
                           input logic [COUNT_BITS-1:0] cnt);
        t_packet_cmd p;
        p.cmd             = c;
        p.src             = s;
        p.dst             = d;
        p.ts              = t;
        p.t_lo            = lo;
        p.t_hi            = hi;
        p.typed           = typed;
        p.typed_res       = '0;
        p.typed_res.status = st;
        p.typed_res.count = cnt;
        script.push_back(p);
    endtask

    int unsigned phase_limit [PHASES] = '{64, 0, 1, 127, 64, 4, 64, 3, 100, 64};
    int          phase_add   [PHASES] = '{45, 50, 55, 45, 80, 70, 85, 55, 50, 40};
    bit          phase_narrow[PHASES] = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0};
    bit          phase_idle  [PHASES] = '{1, 1, 1, 1, 0, 1, 1, 0, 1, 1};

    initial begin
        pkt_if.valid       = 1'b0;
        pkt_if.cmd         = CMD_NOP;
        pkt_if.pkt_source  = '0;
        pkt_if.destination = '0;
        pkt_if.timestamp   = '0;
        pkt_if.start_time  = '0;
        pkt_if.end_time    = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        for (int i = 0; i < SLOTS; i++) fifo_vld[i] = 1'b0;

        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows; typed results where they are obvious
        add_row(CMD_FWD, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0);
        add_row(CMD_CNT, 0, 0, 0, 0, TS_MAX, 1, ST_COUNT, 0);
        add_row(CMD_ADD, 0, 0, 0, 0, 0, 1, ST_ADDED, 0);
        add_row(CMD_ADD, NODE_MAX, NODE_MAX, TS_MAX, TS_MAX, TS_MAX, 1, ST_ADDED, 0);
        add_row(CMD_ADD, 0, 0, 0, TS_MAX, TS_MAX, 1, ST_DUP, 0);
        add_row(CMD_ADD, NODE_MAX, NODE_MAX, TS_MAX, 0, 0, 1, ST_DUP, 0);
        add_row(CMD_ADD, 0, 0, 1, 0, 0, 1, ST_ADDED, 0);
        add_row(CMD_ADD, 1, 0, 0, 0, 0, 1, ST_ADDED, 0);
        add_row(CMD_ADD, 0, 1, 0, 0, 0, 1, ST_ADDED, 0);
        add_row(CMD_CNT, 0, 0, 0, 0, TS_MAX, 0, ST_COUNT, 0);
        add_row(CMD_CNT, 0, 0, 0, 1, 1, 0, ST_COUNT, 0);
        add_row(CMD_CNT, NODE_MAX, NODE_MAX, 0, TS_MAX, TS_MAX, 0, ST_COUNT, 0);
        // start above end: empty range
        add_row(CMD_CNT, 0, 0, 0, 5, 2, 1, ST_COUNT, 0);
        add_row(CMD_CNT, 0, 0, 0, TS_MAX, 0, 1, ST_COUNT, 0);
        add_row(CMD_NOP, NODE_MAX, NODE_MAX, TS_MAX, TS_MAX, TS_MAX, 0, ST_ADDED, 0);
        add_row(CMD_FWD, NODE_MAX, NODE_MAX, TS_MAX, 0, 0, 0, ST_FWD, 0);
        add_row(CMD_FWD, 0, 0, 0, 0, 0, 0, ST_FWD, 0);
        add_row(CMD_ADD, 0, 0, 0, 0, 0, 0, ST_ADDED, 0);
        add_row(CMD_CNT, 0, 1, 0, 0, 0, 0, ST_COUNT, 0);
        repeat (4) add_row(CMD_FWD, 0, 0, 0, 0, 0, 0, ST_FWD, 0);
        add_row(CMD_FWD, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0);

        foreach (script[i]) send_packet(script[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            write_limit(LIMIT_BITS'(phase_limit[ph]));
            sender_idle = phase_idle[ph];
            sink_idle   = phase_idle[ph];
            for (int n = 0; n < PHASE_LEN; n++) begin
                // hold results off while commands keep coming, so input stalls
                if (ph == 4 && n == 20) hold_request = 1'b1;
                send_packet(random_packet(phase_add[ph], phase_narrow[ph]));
            end
        end
        pkt_if.valid = 1'b0;
        sender_idle  = 1'b1;
        sink_idle    = 1'b1;

        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d commands, checked %0d results over limits 0..127.",
                 cmds_sent, results_seen);
        $display("Peak occupancy %0d, largest count %0d, with a long result hold-off.",
                 peak_occ, peak_count);
        if (errors == 0 && awaited_results.size() == 0) begin
            $display("bounded_packet_fifo_dedup_count test passed");
        end else begin
            $display("bounded_packet_fifo_dedup_count test failed");
        end
        $finish;
    end

endmodule
